// ===== src/convex_polygon_overlap_sat_assert.svh =====
// Assertion macros for the polygon overlap block checker.
`ifndef CONVEX_POLYGON_OVERLAP_SAT_ASSERT_SVH
`define CONVEX_POLYGON_OVERLAP_SAT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CPO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cpo_pkg.sv =====
// Shared types and constants of the polygon overlap block.
`default_nettype none

package cpo_pkg;

    localparam int MIN_POLY_VERTICES = 3;

    typedef struct packed {
        logic load;
        logic rot;
    } t_ring_ctl;

    typedef struct packed {
        logic valid;
        logic first;
        logic is_b;
    } t_proj_ctl;

endpackage

`default_nettype wire

// ===== src/cpo_cell.sv =====
// One vertex cell of the rotating store: loads a vertex or takes its neighbor's.
`default_nettype none

module cpo_cell #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic                         i_shift,
    input  wire logic signed [COORD_BITS-1:0] i_x_load,
    input  wire logic signed [COORD_BITS-1:0] i_y_load,
    input  wire logic signed [COORD_BITS-1:0] i_x_next,
    input  wire logic signed [COORD_BITS-1:0] i_y_next,
    output logic signed [COORD_BITS-1:0]      o_x,
    output logic signed [COORD_BITS-1:0]      o_y
);

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_x_load;
            r_y <= i_y_load;
        end else if (i_shift) begin
            r_x <= i_x_next;
            r_y <= i_y_next;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

// ===== src/cpo_ring.sv =====
// Vertex store of one polygon as a ring of cells that rotates over its fill count.
`default_nettype none

module cpo_ring #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 20,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                         i_clk,
    input  wire cpo_pkg::t_ring_ctl           i_ctl,
    input  wire logic [CNT_W-1:0]             i_count,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    output logic signed [COORD_BITS-1:0]      o_head_x,
    output logic signed [COORD_BITS-1:0]      o_head_y,
    output logic signed [COORD_BITS-1:0]      o_second_x,
    output logic signed [COORD_BITS-1:0]      o_second_y
);
    import cpo_pkg::*;

    logic signed [COORD_BITS-1:0] w_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] w_y [MAX_VERTICES];

    // new vertex lands at index count; rotation wraps at count-1
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        logic                         w_load;
        logic signed [COORD_BITS-1:0] w_xn;
        logic signed [COORD_BITS-1:0] w_yn;

        assign w_load = i_ctl.load && (i_count == CNT_W'(g));

        if (g == MAX_VERTICES - 1) begin : g_tail
            assign w_xn = w_x[0];
            assign w_yn = w_y[0];
        end else begin : g_mid
            assign w_xn = (i_count == CNT_W'(g + 1)) ? w_x[0] : w_x[g + 1];
            assign w_yn = (i_count == CNT_W'(g + 1)) ? w_y[0] : w_y[g + 1];
        end

        cpo_cell #(
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_load   (w_load),
            .i_shift  (i_ctl.rot),
            .i_x_load (i_x),
            .i_y_load (i_y),
            .i_x_next (w_xn),
            .i_y_next (w_yn),
            .o_x      (w_x[g]),
            .o_y      (w_y[g])
        );
    end

    assign o_head_x   = w_x[0];
    assign o_head_y   = w_y[0];
    assign o_second_x = w_x[1];
    assign o_second_y = w_y[1];

endmodule

`default_nettype wire

// ===== src/cpo_proj.sv =====
// Projection unit: registered dot product, then running min/max per polygon.
`default_nettype none

module cpo_proj #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cpo_pkg::t_proj_ctl           i_ctl,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic signed [COORD_BITS:0]   i_ax,
    input  wire logic signed [COORD_BITS:0]   i_ay,
    output logic                              o_sep
);
    import cpo_pkg::*;

    localparam int PW = 2 * COORD_BITS + 1;
    localparam int DW = PW + 1;

    t_proj_ctl             r_ctl;
    logic signed [PW-1:0]  r_p1;
    logic signed [PW-1:0]  r_p2;
    logic signed [DW-1:0]  r_mn_a;
    logic signed [DW-1:0]  r_mx_a;
    logic signed [DW-1:0]  r_mn_b;
    logic signed [DW-1:0]  r_mx_b;
    logic signed [DW-1:0]  w_d;
    logic signed [DW-1:0]  w_mn;
    logic signed [DW-1:0]  w_mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= PW'(i_x) * PW'(i_ax);
        r_p2 <= PW'(i_y) * PW'(i_ay);
    end

    assign w_d  = DW'(r_p1) + DW'(r_p2);
    assign w_mn = r_ctl.is_b ? r_mn_b : r_mn_a;
    assign w_mx = r_ctl.is_b ? r_mx_b : r_mx_a;

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            if (r_ctl.is_b) begin
                if (r_ctl.first || w_d < w_mn) r_mn_b <= w_d;
                if (r_ctl.first || w_d > w_mx) r_mx_b <= w_d;
            end else begin
                if (r_ctl.first || w_d < w_mn) r_mn_a <= w_d;
                if (r_ctl.first || w_d > w_mx) r_mx_a <= w_d;
            end
        end
    end

    assign o_sep = (r_mx_a < r_mn_b) || (r_mx_b < r_mn_a);

endmodule

`default_nettype wire

// ===== src/convex_polygon_overlap_sat.sv =====
// Convex polygon overlap test by separating axes over two rotating vertex rings.
//
// Vertices of A and B are loaded one per beat, one per cycle while busy is low. The beat
// that carries i_last_vertex starts the test; busy stays high until the result is out.
// Each edge of A, then of B, gives an axis; one multiply-add unit at the head of the rings
// projects one vertex per cycle, so each axis passes the axis, A projection, B projection,
// drain and check states in turn; a separating axis ends the test early. A degenerate pair
// reports on the next cycle. The result is shown for one cycle on o_valid and cannot be
// held off by the receiver, so it must be taken when it appears.
`default_nettype none

module convex_polygon_overlap_sat #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 20
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_polygon_select,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_y,
    input  wire logic                         i_last_vertex,
    output logic                              o_valid,
    output logic                              o_overlap,
    output logic                              o_degenerate,
    output logic                              o_overflow
);
    import cpo_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_AXIS   = 6'b000010,
        S_PROJ_A = 6'b000100,
        S_PROJ_B = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_CHECK  = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [CNT_W-1:0]             r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]             r_cnt_b, n_cnt_b;
    logic                         r_ovf, n_ovf;
    logic                         r_edge_b, n_edge_b;
    logic [CNT_W-1:0]             r_edge, n_edge;
    logic [CNT_W-1:0]             r_idx, n_idx;
    logic signed [COORD_BITS:0]   r_ax, n_ax;
    logic signed [COORD_BITS:0]   r_ay, n_ay;
    logic                         r_valid, n_valid;
    logic                         r_overlap, n_overlap;
    logic                         r_deg, n_deg;
    logic                         r_ovf_out, n_ovf_out;

    logic                         w_acc;
    logic                         w_full_a;
    logic                         w_full_b;
    logic                         w_drop;
    logic [CNT_W-1:0]             w_after_a;
    logic [CNT_W-1:0]             w_after_b;
    logic [CNT_W-1:0]             w_n_edge;
    logic                         w_sep;
    t_ring_ctl                    w_ctl_a;
    t_ring_ctl                    w_ctl_b;
    t_proj_ctl                    w_pctl;
    logic signed [COORD_BITS-1:0] w_ax0, w_ay0, w_ax1, w_ay1;
    logic signed [COORD_BITS-1:0] w_bx0, w_by0, w_bx1, w_by1;
    logic signed [COORD_BITS-1:0] w_ex0, w_ey0, w_ex1, w_ey1;
    logic signed [COORD_BITS-1:0] w_px, w_py;

    assign busy     = (r_state != S_IDLE);
    assign w_acc    = start && !busy;
    assign w_full_a = (r_cnt_a == CNT_W'(MAX_VERTICES));
    assign w_full_b = (r_cnt_b == CNT_W'(MAX_VERTICES));
    assign w_drop   = i_polygon_select ? w_full_b : w_full_a;

    assign w_after_a = (!i_polygon_select && !w_full_a) ? r_cnt_a + 1'b1 : r_cnt_a;
    assign w_after_b = (i_polygon_select && !w_full_b) ? r_cnt_b + 1'b1 : r_cnt_b;

    assign w_ex0 = r_edge_b ? w_bx0 : w_ax0;
    assign w_ey0 = r_edge_b ? w_by0 : w_ay0;
    assign w_ex1 = r_edge_b ? w_bx1 : w_ax1;
    assign w_ey1 = r_edge_b ? w_by1 : w_ay1;
    assign w_n_edge = r_edge_b ? r_cnt_b : r_cnt_a;

    assign w_px = (r_state == S_PROJ_B) ? w_bx0 : w_ax0;
    assign w_py = (r_state == S_PROJ_B) ? w_by0 : w_ay0;

    always_comb begin
        w_ctl_a.load = w_acc && !i_polygon_select && !w_full_a;
        w_ctl_b.load = w_acc && i_polygon_select && !w_full_b;
        w_ctl_a.rot  = (r_state == S_PROJ_A) || (r_state == S_CHECK && !w_sep && !r_edge_b);
        w_ctl_b.rot  = (r_state == S_PROJ_B) || (r_state == S_CHECK && !w_sep && r_edge_b);
        w_pctl.valid = (r_state == S_PROJ_A) || (r_state == S_PROJ_B);
        w_pctl.first = (r_idx == '0);
        w_pctl.is_b  = (r_state == S_PROJ_B);
    end

    always_comb begin
        n_state   = r_state;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_ovf     = r_ovf;
        n_edge_b  = r_edge_b;
        n_edge    = r_edge;
        n_idx     = r_idx;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_valid   = 1'b0;
        n_overlap = r_overlap;
        n_deg     = r_deg;
        n_ovf_out = r_ovf_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_cnt_a = w_after_a;
                    n_cnt_b = w_after_b;
                    n_ovf   = r_ovf || w_drop;
                    if (i_last_vertex) begin
                        if (w_after_a < CNT_W'(MIN_POLY_VERTICES) ||
                            w_after_b < CNT_W'(MIN_POLY_VERTICES)) begin
                            n_valid   = 1'b1;
                            n_overlap = 1'b0;
                            n_deg     = 1'b1;
                            n_ovf_out = r_ovf || w_drop;
                            n_cnt_a   = '0;
                            n_cnt_b   = '0;
                            n_ovf     = 1'b0;
                        end else begin
                            n_state  = S_AXIS;
                            n_edge   = '0;
                            n_edge_b = 1'b0;
                        end
                    end
                end
            end
            S_AXIS: begin
                n_ax    = (COORD_BITS + 1)'(w_ey0) - (COORD_BITS + 1)'(w_ey1);
                n_ay    = (COORD_BITS + 1)'(w_ex1) - (COORD_BITS + 1)'(w_ex0);
                n_idx   = '0;
                n_state = S_PROJ_A;
            end
            S_PROJ_A: begin
                if (r_idx == r_cnt_a - 1'b1) begin
                    n_idx   = '0;
                    n_state = S_PROJ_B;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PROJ_B: begin
                if (r_idx == r_cnt_b - 1'b1) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_sep || (r_edge == w_n_edge - 1'b1 && r_edge_b)) begin
                    n_valid   = 1'b1;
                    n_overlap = !w_sep;
                    n_deg     = 1'b0;
                    n_ovf_out = r_ovf;
                    n_cnt_a   = '0;
                    n_cnt_b   = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_IDLE;
                end else if (r_edge == w_n_edge - 1'b1) begin
                    n_edge_b = 1'b1;
                    n_edge   = '0;
                    n_state  = S_AXIS;
                end else begin
                    n_edge  = r_edge + 1'b1;
                    n_state = S_AXIS;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge_b  <= n_edge_b;
        r_edge    <= n_edge;
        r_idx     <= n_idx;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_overlap <= n_overlap;
        r_deg     <= n_deg;
        r_ovf_out <= n_ovf_out;
    end

    cpo_ring #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS),
        .CNT_W       (CNT_W)
    ) u_ring_a (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl_a),
        .i_count    (r_cnt_a),
        .i_x        (i_vertex_x),
        .i_y        (i_vertex_y),
        .o_head_x   (w_ax0),
        .o_head_y   (w_ay0),
        .o_second_x (w_ax1),
        .o_second_y (w_ay1)
    );

    cpo_ring #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS),
        .CNT_W       (CNT_W)
    ) u_ring_b (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl_b),
        .i_count    (r_cnt_b),
        .i_x        (i_vertex_x),
        .i_y        (i_vertex_y),
        .o_head_x   (w_bx0),
        .o_head_y   (w_by0),
        .o_second_x (w_bx1),
        .o_second_y (w_by1)
    );

    cpo_proj #(
        .COORD_BITS(COORD_BITS)
    ) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_pctl),
        .i_x     (w_px),
        .i_y     (w_py),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .o_sep   (w_sep)
    );

    assign o_valid      = r_valid;
    assign o_overlap    = r_overlap;
    assign o_degenerate = r_deg;
    assign o_overflow   = r_ovf_out;

endmodule

`default_nettype wire

// ===== src/cpo_checker.sv =====
// Port-level checks of the polygon overlap block, bound to its top level.
`default_nettype none

`include "convex_polygon_overlap_sat_assert.svh"

module cpo_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_last_vertex,
    input wire logic o_valid,
    input wire logic o_overlap,
    input wire logic o_degenerate
);

    // a result always comes with the block back in idle
    `CPO_ASSERT_NOW(a_result_idle, o_valid, !busy, "result while busy")

    `CPO_ASSERT_NOW(a_deg_no_overlap, o_valid && o_degenerate, !o_overlap,
                    "degenerate result claims overlap")

    // only the closing beat of a pair produces a result
    `CPO_ASSERT_NEXT(a_mid_beat_silent, start && !busy && !i_last_vertex, !o_valid,
                     "result after a non-final beat")

    `CPO_ASSERT_NOW(a_busy_from_last, $rose(busy), $past(start && i_last_vertex),
                    "busy rose without a final beat")

endmodule

bind convex_polygon_overlap_sat cpo_checker u_cpo_checker (.*);

`default_nettype wire
